>>> hdl/hbsd_pkg.sv
package hbsd_pkg;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BIT   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic start;
        logic cmp_en;
    } scan_ctl_t;

endpackage

>>> hdl/hbsd_req_if.sv
interface hbsd_req_if;
    logic                         valid;
    logic                         ready;
    logic [hbsd_pkg::REQ_W-1:0]   req_type;
    logic [hbsd_pkg::SYM_W-1:0]   entry_symbol;
    logic [hbsd_pkg::CODE_W-1:0]  entry_code;
    logic [hbsd_pkg::LEN_W-1:0]   entry_length;
    logic                         code_bit;

    modport source (
        output valid, req_type, entry_symbol, entry_code, entry_length, code_bit,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_symbol, entry_code, entry_length, code_bit,
        output ready
    );
endinterface

>>> hdl/hbsd_res_if.sv
interface hbsd_res_if;
    logic                         valid;
    logic                         ready;
    logic                         symbol_valid;
    logic [hbsd_pkg::SYM_W-1:0]   symbol;
    logic [hbsd_pkg::STAT_W-1:0]  status;

    modport source (
        output valid, symbol_valid, symbol, status,
        input  ready
    );
    modport sink (
        input  valid, symbol_valid, symbol, status,
        output ready
    );
endinterface

>>> hdl/hbsd_ram.sv
module hbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/hbsd_match.sv
module hbsd_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hbsd_pkg::scan_ctl_t           ctl,
    input  hbsd_pkg::entry_t              entry,
    input  logic [hbsd_pkg::CODE_W-1:0]   accum_bits,
    input  logic [hbsd_pkg::LEN_W-1:0]    accum_len,
    output logic                          hit,
    output logic [hbsd_pkg::SYM_W-1:0]    symbol
);

    logic                        hit_reg;
    logic [hbsd_pkg::SYM_W-1:0]  symbol_reg;
    logic                        match;

    assign match = (entry.length == accum_len) && (entry.code == accum_bits);

    // later entries overwrite earlier ones, so the last loaded match wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.cmp_en && match)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en && match)
        begin
            symbol_reg <= entry.symbol;
        end
    end

    assign hit    = hit_reg;
    assign symbol = symbol_reg;

endmodule

>>> hdl/huffman_bit_serial_decoder.sv
// Bit-serial Huffman decoder with a loadable code table. Every item on req
// gives exactly one item on res. A clear item (req_type 0) empties the table
// and the bit accumulator; a load item (1) appends one (symbol, code, length)
// entry, or reports table full or bad length; a code bit item (2) shifts one
// stream bit, first bit most significant, into the accumulator and then reads
// the table back one entry per cycle through a single compare unit, the last
// loaded matching entry giving the symbol. Reaching the maximum code length
// with no match reports overflow and restarts the accumulator. Clear, load and
// unused items are answered from S_IDLE; a bit item passes through S_SCAN,
// S_LAST and S_DONE, or straight to S_DONE with an empty table. req.ready is
// also low while a finished item waits on res. The table memory is not
// cleared: only entries below the fill count are ever read.
module huffman_bit_serial_decoder #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_LEN  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    hbsd_req_if.sink  req,
    hbsd_res_if.source res
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    // usable code length, capped by the accumulator width
    localparam int USABLE_LEN = (MAX_CODE_LEN < hbsd_pkg::CODE_W) ?
                                MAX_CODE_LEN : hbsd_pkg::CODE_W;
    localparam logic [hbsd_pkg::LEN_W-1:0] USABLE = hbsd_pkg::LEN_W'(USABLE_LEN);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [hbsd_pkg::CODE_W-1:0]     accum_bits_reg, accum_bits_next;
    logic [hbsd_pkg::LEN_W-1:0]      accum_len_reg, accum_len_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            sym_valid_reg, sym_valid_next;
    logic [hbsd_pkg::SYM_W-1:0]      symbol_reg, symbol_next;
    logic [hbsd_pkg::STAT_W-1:0]     status_reg, status_next;

    logic                            accept;
    logic                            out_free;
    logic [CNT_W-1:0]                cnt_last;
    logic [hbsd_pkg::CODE_W:0]       mask_wide;
    logic                            ram_we;
    hbsd_pkg::entry_t                ram_wdata;
    hbsd_pkg::entry_t                ram_rdata;
    hbsd_pkg::scan_ctl_t             scan_ctl;
    logic                            hit;
    logic [hbsd_pkg::SYM_W-1:0]      hit_symbol;

    // output register can take a new item this cycle
    assign out_free = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept = req.valid && req.ready;
    assign cnt_last = count_reg - CNT_W'(1);

    // keep only the low entry_length bits of a loaded code
    assign mask_wide = ({{hbsd_pkg::CODE_W{1'b0}}, 1'b1} << req.entry_length)
                       - (hbsd_pkg::CODE_W + 1)'(1);

    assign ram_wdata.symbol = req.entry_symbol;
    assign ram_wdata.code   = req.entry_code & mask_wide[hbsd_pkg::CODE_W-1:0];
    assign ram_wdata.length = req.entry_length;

    hbsd_ram #(
        .WIDTH (hbsd_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    hbsd_match u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .entry      (ram_rdata),
        .accum_bits (accum_bits_reg),
        .accum_len  (accum_len_reg),
        .hit        (hit),
        .symbol     (hit_symbol)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = (state_reg == S_SCAN);
        accum_bits_next = accum_bits_reg;
        accum_len_next  = accum_len_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        sym_valid_next  = sym_valid_reg;
        symbol_next     = symbol_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        scan_ctl.start  = 1'b0;
        scan_ctl.cmp_en = cmp_vld_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        hbsd_pkg::REQ_CLEAR:
                        begin
                            count_next      = '0;
                            accum_bits_next = '0;
                            accum_len_next  = '0;
                            out_valid_next  = 1'b1;
                            sym_valid_next  = 1'b0;
                            symbol_next     = '0;
                            status_next     = hbsd_pkg::ST_OK;
                        end
                        hbsd_pkg::REQ_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            sym_valid_next = 1'b0;
                            symbol_next    = '0;
                            // length check comes before the table full check
                            if (req.entry_length == '0 || req.entry_length > USABLE)
                            begin
                                status_next = hbsd_pkg::ST_BAD_LEN;
                            end
                            else if (count_reg >= CNT_FULL)
                            begin
                                status_next = hbsd_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = hbsd_pkg::ST_OK;
                                ram_we      = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        hbsd_pkg::REQ_BIT:
                        begin
                            accum_bits_next = {accum_bits_reg[hbsd_pkg::CODE_W-2:0],
                                               req.code_bit};
                            accum_len_next  = accum_len_reg + hbsd_pkg::LEN_W'(1);
                            scan_ctl.start  = 1'b1;
                            idx_next        = '0;
                            state_next      = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        default:
                        begin
                            // unused request code: no state change, zero item
                            out_valid_next = 1'b1;
                            sym_valid_next = 1'b0;
                            symbol_next    = '0;
                            status_next    = hbsd_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == cnt_last[IDX_W-1:0])
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_LAST:
            begin
                // last read data is compared this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sym_valid_next = hit;
                    symbol_next    = hit ? hit_symbol : '0;
                    if (hit)
                    begin
                        status_next     = hbsd_pkg::ST_OK;
                        accum_bits_next = '0;
                        accum_len_next  = '0;
                    end
                    else if (accum_len_reg >= USABLE)
                    begin
                        status_next     = hbsd_pkg::ST_OVERFLOW;
                        accum_bits_next = '0;
                        accum_len_next  = '0;
                    end
                    else
                    begin
                        status_next = hbsd_pkg::ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            accum_bits_reg <= '0;
            accum_len_reg  <= '0;
            out_valid_reg  <= 1'b0;
            sym_valid_reg  <= 1'b0;
            symbol_reg     <= '0;
            status_reg     <= hbsd_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            accum_bits_reg <= accum_bits_next;
            accum_len_reg  <= accum_len_next;
            out_valid_reg  <= out_valid_next;
            sym_valid_reg  <= sym_valid_next;
            symbol_reg     <= symbol_next;
            status_reg     <= status_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.symbol_valid = sym_valid_reg;
    assign res.symbol       = symbol_reg;
    assign res.status       = status_reg;

    // accumulator never grows past the usable code length
    a_accum_len: assert property (@(posedge clk) disable iff (!rst_n)
        accum_len_reg <= USABLE)
        else $error("accumulator length beyond usable code length");

    // fill count never passes the table depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("table fill count beyond table depth");

    // a decoded symbol always comes with status ok
    a_sym_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.symbol_valid |-> res.status == hbsd_pkg::ST_OK)
        else $error("decoded symbol with error status");

    // an accepted bit item leaves a non-empty accumulator while it is scanned
    a_bit_len: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == hbsd_pkg::REQ_BIT |=> accum_len_reg != '0)
        else $error("bit item did not extend the accumulator");

endmodule

>>> bench/huffman_bit_serial_decoder_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the bit-serial Huffman decoder.
// An initial block builds the whole request stream up front: a short directed
// run over the corner cases, then random phases made mostly of well-formed
// prefix codes (clear, load the table, stream the code bits of random
// symbols), with random noise, overflow runs and one pass with a full table.
// A clocked driver feeds the stream to the req channel, a clocked monitor
// predicts the decoder output for every accepted request and checks each
// item on res against the oldest prediction.
module huffman_bit_serial_decoder_tb;

    localparam int TABLE_N = 256;
    localparam int MAX_LEN = 32;
    // the accumulator is 32 bits wide, so longer codes can never complete
    localparam int USE_LEN = (MAX_LEN < 32) ? MAX_LEN : 32;

    // request type 3 is not decoded by the block and must be ignored
    localparam logic [hbsd_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int N_ITEMS  = 1000;
    // idling stops once this few requests are left to send
    localparam int CALM_TAIL = 120;
    // slowest bit item is a full-table scan; both sides may idle on top of it
    localparam int DRAIN    = TABLE_N + 16;
    localparam int WATCHDOG = 4 * (TABLE_N + 3 + 7 + 7);

    typedef struct packed {
        logic [hbsd_pkg::REQ_W-1:0]  kind;
        logic [hbsd_pkg::SYM_W-1:0]  sym;
        logic [hbsd_pkg::CODE_W-1:0] code;
        logic [hbsd_pkg::LEN_W-1:0]  len;
        logic                        cbit;
    } stream_req_t;

    typedef struct packed {
        logic                        hit;
        logic [hbsd_pkg::SYM_W-1:0]  sym;
        logic [hbsd_pkg::STAT_W-1:0] st;
    } decoded_t;

    logic clk;
    logic rst_n;

    hbsd_req_if req_ch ();
    hbsd_res_if res_ch ();

    huffman_bit_serial_decoder #(
        .TABLE_ENTRIES (TABLE_N),
        .MAX_CODE_LEN  (MAX_LEN)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // requests still to be sent, and decoder outputs still to arrive
    stream_req_t stream_q[$];
    decoded_t    decoded_q[$];

    int n_items;        // requests queued, ignored ones not counted
    int n_total;
    int n_accepted;
    int n_fail;
    int idle_cycles;
    int req_gap;
    int res_stall;
    stream_req_t nxt;

    // shadow of the decoder state
    logic [hbsd_pkg::SYM_W-1:0]  tbl_sym  [TABLE_N];
    logic [hbsd_pkg::CODE_W-1:0] tbl_code [TABLE_N];
    int                          tbl_len  [TABLE_N];
    int                          fill_cnt;
    logic [31:0]                 acc_bits;
    int                          acc_len;

    // leaves of the prefix code under construction
    logic [31:0] lf_code[$];
    int          lf_len[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // decoder prediction, one request in, one output item out
    // ------------------------------------------------------------------
    function automatic decoded_t decode_item(input stream_req_t r);
        decoded_t o;
        logic [63:0] keep;
        o = '0;
        case (r.kind)
            hbsd_pkg::REQ_CLEAR:
            begin
                fill_cnt = 0;
                acc_bits = '0;
                acc_len  = 0;
            end
            hbsd_pkg::REQ_LOAD:
            begin
                // length check takes priority over table full
                if (r.len == 0 || r.len > USE_LEN)
                    o.st = hbsd_pkg::ST_BAD_LEN;
                else if (fill_cnt >= TABLE_N)
                    o.st = hbsd_pkg::ST_FULL;
                else
                begin
                    // code bits above the length are dropped on store
                    keep = (64'd1 << r.len) - 64'd1;
                    tbl_sym[fill_cnt]  = r.sym;
                    tbl_code[fill_cnt] = r.code & keep[31:0];
                    tbl_len[fill_cnt]  = int'(r.len);
                    fill_cnt++;
                end
            end
            hbsd_pkg::REQ_BIT:
            begin
                acc_bits = {acc_bits[30:0], r.cbit};
                acc_len++;
                // later entries overwrite earlier ones: last loaded match wins
                for (int i = 0; i < fill_cnt; i++)
                begin
                    if (tbl_len[i] == acc_len && tbl_code[i] == acc_bits)
                    begin
                        o.hit = 1'b1;
                        o.sym = tbl_sym[i];
                    end
                end
                if (o.hit || acc_len >= USE_LEN)
                begin
                    if (!o.hit)
                        o.st = hbsd_pkg::ST_OVERFLOW;
                    acc_bits = '0;
                    acc_len  = 0;
                end
            end
            default:
            begin
                // unused request type: no state change, all-zero output
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // request stream building
    // ------------------------------------------------------------------
    task automatic push_req(input logic [hbsd_pkg::REQ_W-1:0] kind,
                            input logic [hbsd_pkg::SYM_W-1:0] sym,
                            input logic [hbsd_pkg::CODE_W-1:0] code,
                            input logic [hbsd_pkg::LEN_W-1:0] len,
                            input logic cbit);
        stream_req_t r;
        r.kind = kind;
        r.sym  = sym;
        r.code = code;
        r.len  = len;
        r.cbit = cbit;
        stream_q.push_back(r);
        if (kind != REQ_UNUSED)
            n_items++;
    endtask

    // unused fields carry junk so that the block must ignore them
    task automatic push_bit(input logic b);
        push_req(hbsd_pkg::REQ_BIT, hbsd_pkg::SYM_W'($urandom()), $urandom(),
                 hbsd_pkg::LEN_W'($urandom()), b);
    endtask

    task automatic push_clear();
        push_req(hbsd_pkg::REQ_CLEAR, hbsd_pkg::SYM_W'($urandom()), $urandom(),
                 hbsd_pkg::LEN_W'($urandom()), 1'($urandom()));
    endtask

    task automatic push_load(input logic [hbsd_pkg::SYM_W-1:0] sym,
                             input logic [hbsd_pkg::CODE_W-1:0] code,
                             input logic [hbsd_pkg::LEN_W-1:0] len);
        push_req(hbsd_pkg::REQ_LOAD, sym, code, len, 1'($urandom()));
    endtask

    task automatic push_leaf_bits(input int j);
        for (int b = lf_len[j] - 1; b >= 0; b--)
            push_bit(lf_code[j][b]);
    endtask

    // grow a full binary code tree by splitting leaves; chain mode always
    // splits the newest leaf, giving codes of every length up to one less than the leaf count
    task automatic grow_code(input int n, input int cap, input bit chain);
        int pick;
        int tries;
        logic [31:0] c;
        int l;
        lf_code = {32'd0};
        lf_len  = {0};
        tries   = 0;
        while (lf_code.size() < n && tries < 1000)
        begin
            tries++;
            pick = chain ? lf_code.size() - 1 : $urandom_range(0, lf_code.size() - 1);
            if (lf_len[pick] < cap)
            begin
                c = lf_code[pick];
                l = lf_len[pick];
                lf_code[pick] = {c[30:0], 1'b0};
                lf_len[pick]  = l + 1;
                lf_code.push_back({c[30:0], 1'b1});
                lf_len.push_back(l + 1);
            end
        end
    endtask

    // clear, load a prefix code (maybe with a hole or a redefined code),
    // then stream random symbols of it
    task automatic well_formed();
        bit chain;
        int n;
        int cap;
        int drop;
        int j;
        logic [31:0] junk;
        chain = ($urandom_range(0, 7) == 0);
        n     = chain ? $urandom_range(20, USE_LEN + 1) : $urandom_range(2, 12);
        cap   = chain ? USE_LEN : $urandom_range(3, 10);
        grow_code(n, cap, chain);
        drop  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lf_code.size() - 1) : -1;
        push_clear();
        for (int i = 0; i < lf_code.size(); i++)
        begin
            if (i != drop)
            begin
                junk = $urandom_range(0, 1) ? ($urandom() << lf_len[i]) : 32'd0;
                push_load(hbsd_pkg::SYM_W'($urandom()), lf_code[i] | junk,
                          hbsd_pkg::LEN_W'(lf_len[i]));
            end
        end
        // redefine one code: the later entry should win
        if ($urandom_range(0, 4) == 0)
        begin
            j = $urandom_range(0, lf_code.size() - 1);
            push_load(hbsd_pkg::SYM_W'($urandom()), lf_code[j],
                      hbsd_pkg::LEN_W'(lf_len[j]));
        end
        for (int k = $urandom_range(8, 30); k > 0; k--)
            push_leaf_bits($urandom_range(0, lf_code.size() - 1));
        // sometimes leave a partial code hanging before the next clear
        if ($urandom_range(0, 3) == 0)
            for (int k = $urandom_range(1, 3); k > 0; k--)
                push_bit(1'($urandom()));
    endtask

    // unstructured requests over the whole field ranges
    task automatic noise();
        int pick;
        for (int k = $urandom_range(5, 20); k > 0; k--)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                push_req(REQ_UNUSED, hbsd_pkg::SYM_W'($urandom()), $urandom(),
                         hbsd_pkg::LEN_W'($urandom()), 1'($urandom()));
            else if (pick < 15)
                push_clear();
            else if (pick < 55)
                push_load(hbsd_pkg::SYM_W'($urandom()), $urandom(),
                          hbsd_pkg::LEN_W'($urandom_range(0, 63)));
            else
                push_bit(1'($urandom()));
        end
    endtask

    // empty table: bits only pile up until the accumulator overflows
    task automatic overflow_run();
        push_clear();
        for (int k = $urandom_range(USE_LEN, USE_LEN + 8); k > 0; k--)
            push_bit(1'($urandom()));
    endtask

    // fill every slot, check both rejections, then decode one stored code
    task automatic full_table();
        int pick;
        logic [31:0] code;
        int len;
        logic [31:0] hit_code;
        int hit_len;
        pick = $urandom_range(0, TABLE_N - 1);
        hit_code = '0;
        hit_len  = 1;
        push_clear();
        for (int i = 0; i < TABLE_N; i++)
        begin
            code = $urandom();
            len  = (i == pick) ? $urandom_range(8, USE_LEN) : $urandom_range(1, USE_LEN);
            if (i == pick)
            begin
                hit_code = code;
                hit_len  = len;
            end
            push_load(hbsd_pkg::SYM_W'($urandom()), code, hbsd_pkg::LEN_W'(len));
        end
        push_load(hbsd_pkg::SYM_W'($urandom()), hit_code, hbsd_pkg::LEN_W'(hit_len));
        push_load(hbsd_pkg::SYM_W'($urandom()), $urandom(), 6'd0);
        for (int b = hit_len - 1; b >= 0; b--)
            push_bit(hit_code[b]);
    endtask

    function automatic bit winding_down();
        return stream_q.size() < CALM_TAIL;
    endfunction

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.entry_symbol = '0;
        req_ch.entry_code   = '0;
        req_ch.entry_length = '0;
        req_ch.code_bit     = 1'b0;
        res_ch.ready        = 1'b0;
        n_items    = 0;
        n_accepted = 0;
        n_fail     = 0;
        idle_cycles = 0;
        req_gap    = 0;
        res_stall  = 0;
        fill_cnt   = 0;
        acc_bits   = '0;
        acc_len    = 0;

        // directed corner cases
        push_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b1);
        push_load(8'h01, 32'h0, 6'd0);                      // zero length
        push_load(8'h02, 32'h1, hbsd_pkg::LEN_W'(USE_LEN + 1)); // just too long
        push_load(8'h03, 32'hFFFF_FFFF, 6'h3F);             // widest length field
        push_load(8'hFF, 32'hFFFF_FFFF, hbsd_pkg::LEN_W'(USE_LEN)); // longest legal code
        push_load(8'h00, 32'hFFFF_FFF0, 6'd1);              // high junk dropped, code 0
        push_load(8'hA5, 32'h1, 6'd1);
        push_load(8'h3C, 32'h0, 6'd1);                      // redefines code 0
        push_bit(1'b0);
        push_bit(1'b1);
        push_clear();
        push_bit(1'b1);                                     // empty table, accumulates
        push_req(REQ_UNUSED, 8'h00, 32'h0, 6'h0, 1'b0);
        push_clear();                                       // drops the pending bit
        push_load(8'h11, 32'h2, 6'd2);
        push_bit(1'b1);
        push_bit(1'b0);
        push_load(8'h22, 32'h3, 6'd2);
        push_bit(1'b1);
        push_bit(1'b1);
        push_bit(1'b0);                                     // partial code left over
        push_clear();

        // random phases
        full_table();
        while (n_items < N_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:    noise();
                2:       overflow_run();
                default: well_formed();
            endcase
        end
        n_total = stream_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (n_accepted < n_total || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        n_fail = n_fail + decoded_q.size();
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // request driver, payload changes only on an accepted or empty slot
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_gap > 0)
            begin
                req_gap = req_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (stream_q.size() != 0 && !winding_down() && $urandom_range(0, 11) == 0)
            begin
                // idle burst of random length, counted down in req_gap
                req_gap = $urandom_range(0, 6);
                req_ch.valid <= 1'b0;
            end
            else if (stream_q.size() != 0)
            begin
                nxt = stream_q.pop_front();
                req_ch.req_type     <= nxt.kind;
                req_ch.entry_symbol <= nxt.sym;
                req_ch.entry_code   <= nxt.code;
                req_ch.entry_length <= nxt.len;
                req_ch.code_bit     <= nxt.cbit;
                req_ch.valid        <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result back-pressure in bursts of random length
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (res_stall > 0)
        begin
            res_stall = res_stall - 1;
            res_ch.ready <= 1'b0;
        end
        else if (!winding_down() && $urandom_range(0, 7) == 0)
        begin
            res_stall = $urandom_range(0, 6);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // monitor: predict on every accepted request, check every accepted item
    always @(posedge clk)
    begin
        stream_req_t seen;
        decoded_t    got;
        decoded_t    want;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;

            if (req_ch.valid && req_ch.ready)
            begin
                seen.kind = req_ch.req_type;
                seen.sym  = req_ch.entry_symbol;
                seen.code = req_ch.entry_code;
                seen.len  = req_ch.entry_length;
                seen.cbit = req_ch.code_bit;
                decoded_q.push_back(decode_item(seen));
                n_accepted  = n_accepted + 1;
                idle_cycles = 0;
            end

            if (res_ch.valid && res_ch.ready)
            begin
                idle_cycles = 0;
                got.hit = res_ch.symbol_valid;
                got.sym = res_ch.symbol;
                got.st  = res_ch.status;
                if (decoded_q.size() == 0)
                begin
                    n_fail = n_fail + 1;
                    if (n_fail <= 10)
                        $display("unexpected item: valid %0b symbol %02h status %0d",
                                 got.hit, got.sym, got.st);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got.hit !== want.hit || got.sym !== want.sym || got.st !== want.st)
                    begin
                        n_fail = n_fail + 1;
                        if (n_fail <= 10)
                            $display(
                                "mismatch (valid symbol status): want %0b %02h %0d, got %0b %02h %0d",
                                want.hit, want.sym, want.st, got.hit, got.sym, got.st);
                    end
                end
            end

            // nothing moved on either channel for far too long
            if (idle_cycles >= WATCHDOG)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
